>>> rtl/rmts_pkg.sv
// Shared types and constants for the rate-monotonic tick scheduler.
// Used by rmts_slot_eval and rate_monotonic_tick_scheduler; no dependencies.
package rmts_pkg;

  localparam int TIME_W = 32;
  localparam int WORD_W = 16;

  // Request action codes; the unused code behaves as a tick
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [3:0]        task_index;
    logic [WORD_W-1:0] task_period;
    logic [WORD_W-1:0] task_cost;
    logic [WORD_W-1:0] task_offset;
  } req_t;

  typedef struct packed {
    logic              busy_res;
    logic [3:0]        running_task;
    logic              job_finished;
    logic [TIME_W-1:0] time_now;
  } res_t;

  // One slot entry of the task table
  typedef struct packed {
    logic [WORD_W-1:0] period;
    logic [WORD_W-1:0] cost;
    logic [WORD_W-1:0] offset;
    logic [TIME_W-1:0] next_release;
    logic [WORD_W-1:0] work_done;
  } slot_word_t;

  // Outcome of evaluating one slot during a tick scan
  typedef struct packed {
    logic release_job;
    logic take;
  } slot_eval_t;

endpackage

>>> rtl/rmts_slot_eval.sv
// Per-slot release test and priority compare, shared across the scan.
// Depends on rmts_pkg.
module rmts_slot_eval import rmts_pkg::*; (
  input  slot_word_t        entry,
  input  logic              valid_bit,
  input  logic              ready_bit,
  input  logic [TIME_W-1:0] cur_time,
  input  logic              have,
  input  logic [WORD_W-1:0] best_period,
  output slot_eval_t        ev
);

  logic [TIME_W-1:0] diff;
  logic              due;
  logic              cand;

  // due when the release is at or before now under wrap-around
  assign diff = cur_time - entry.next_release;
  assign due  = !diff[TIME_W-1];

  assign ev.release_job = valid_bit && !ready_bit && due;
  assign cand           = valid_bit && (ready_bit || ev.release_job);
  // strict compare keeps the lower index on ties
  assign ev.take        = cand && (!have || (entry.period < best_period));

endmodule

>>> rtl/rate_monotonic_tick_scheduler.sv
// Rate-monotonic tick scheduler.
// Request channel (req_valid/req_ready/req) takes one of: load a task slot,
// start the schedule, or one time tick. Response channel (res_valid/res_ready/
// res) returns exactly one result per request, in order.
// A tick scans the slot table once, one slot per cycle through a single
// read port and one shared compare unit (release test and period compare),
// then updates the picked job in the finish state. The block takes one
// request at a time; req_ready is high only while it is idle, so a new
// request waits until the last one's result is in the output register.
// A finished result sits in the output register; when the receiver stalls the
// block holds the next result internally and stays busy until res is taken.
// Reset clears slot valid bits, ready jobs, time and the output register;
// the slot table itself is not cleared, and only valid slots are ever used.
// Depends on rmts_pkg and rmts_slot_eval.
module rate_monotonic_tick_scheduler import rmts_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t                 state;
  logic                   mode_start;
  logic [CW-1:0]          cnt;
  logic                   eval_vld;
  logic [AW-1:0]          eval_idx;
  logic [MAX_TASKS-1:0]   slot_valid;
  logic [MAX_TASKS-1:0]   job_ready;
  logic [TIME_W-1:0]      cur_time;
  logic                   have;
  logic [AW-1:0]          pick;
  slot_word_t             best;
  res_t                   result;

  slot_word_t             mem [MAX_TASKS];
  slot_word_t             rdata;
  logic [AW-1:0]          raddr;
  logic                   we;
  logic [AW-1:0]          waddr;
  slot_word_t             wdata;

  logic [AW+3:0]          ld_wide;
  logic [AW-1:0]          ld_addr;
  logic                   ld_in_range;
  logic [AW+3:0]          pick_wide;
  logic                   accept;

  slot_eval_t             ev;
  slot_word_t             released;
  logic [WORD_W-1:0]      wd_inc;
  logic                   fin;

  assign req_ready   = (state == S_IDLE);
  assign accept      = req_valid && req_ready;
  assign ld_wide     = (AW+4)'(req.task_index);
  assign ld_addr     = ld_wide[AW-1:0];
  assign ld_in_range = ld_wide < (AW+4)'(MAX_TASKS);
  assign pick_wide   = (AW+4)'(pick);
  assign raddr       = (cnt < CW'(MAX_TASKS)) ? cnt[AW-1:0] : '0;

  rmts_slot_eval u_eval (
    .entry       (rdata),
    .valid_bit   (slot_valid[eval_idx]),
    .ready_bit   (job_ready[eval_idx]),
    .cur_time    (cur_time),
    .have        (have),
    .best_period (best.period),
    .ev          (ev)
  );

  always_comb begin
    released           = rdata;
    released.work_done = '0;
  end

  // finishing step for the picked job
  assign wd_inc = (best.work_done == {WORD_W{1'b1}}) ? best.work_done
                                                     : best.work_done + 1'b1;
  assign fin    = wd_inc >= best.cost;

  // table write port
  always_comb begin
    we    = 1'b0;
    waddr = eval_idx;
    wdata = rdata;
    case (state)
      S_IDLE: begin
        if (accept && req.action == ACT_LOAD && ld_in_range) begin
          we                 = 1'b1;
          waddr              = ld_addr;
          wdata.period       = req.task_period;
          wdata.cost         = req.task_cost;
          wdata.offset       = req.task_offset;
          wdata.next_release = TIME_W'(req.task_offset);
          wdata.work_done    = '0;
        end
      end
      S_SCAN: begin
        if (eval_vld) begin
          if (mode_start) begin
            we                 = 1'b1;
            wdata.next_release = TIME_W'(rdata.offset);
            wdata.work_done    = '0;
          end else if (ev.release_job) begin
            we    = 1'b1;
            wdata = released;
          end
        end
      end
      S_FINISH: begin
        if (have) begin
          we    = 1'b1;
          waddr = pick;
          wdata = best;
          if (fin) begin
            wdata.work_done    = '0;
            wdata.next_release = best.next_release + TIME_W'(best.period);
          end else begin
            wdata.work_done = wd_inc;
          end
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode_start <= 1'b0;
      cnt        <= '0;
      eval_vld   <= 1'b0;
      eval_idx   <= '0;
      slot_valid <= '0;
      job_ready  <= '0;
      cur_time   <= '0;
      have       <= 1'b0;
      pick       <= '0;
      best       <= '0;
      result     <= '0;
      res_valid  <= 1'b0;
      res        <= '0;
    end else begin
      // S_EMIT refills the output register itself
      if (res_valid && res_ready && state != S_EMIT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cnt  <= '0;
            have <= 1'b0;
            case (req.action)
              ACT_LOAD: begin
                if (ld_in_range) begin
                  slot_valid[ld_addr] <= 1'b1;
                  job_ready[ld_addr]  <= 1'b0;
                end
                result <= {1'b0, 4'd0, 1'b0, cur_time};
                state  <= S_EMIT;
              end
              ACT_START: begin
                cur_time   <= '0;
                job_ready  <= '0;
                mode_start <= 1'b1;
                state      <= S_SCAN;
              end
              default: begin
                mode_start <= 1'b0;
                state      <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (cnt < CW'(MAX_TASKS)) begin
            cnt      <= cnt + 1'b1;
            eval_vld <= 1'b1;
            eval_idx <= cnt[AW-1:0];
          end else begin
            eval_vld <= 1'b0;
          end
          if (eval_vld) begin
            if (!mode_start) begin
              if (ev.release_job) begin
                job_ready[eval_idx] <= 1'b1;
              end
              if (ev.take) begin
                have <= 1'b1;
                pick <= eval_idx;
                best <= ev.release_job ? released : rdata;
              end
            end
            if (eval_idx == AW'(MAX_TASKS - 1)) begin
              if (mode_start) begin
                result <= {1'b0, 4'd0, 1'b0, cur_time};
                state  <= S_EMIT;
              end else begin
                state <= S_FINISH;
              end
            end
          end
        end
        S_FINISH: begin
          result   <= {have, have ? pick_wide[3:0] : 4'd0, have && fin, cur_time};
          cur_time <= cur_time + 1'b1;
          if (have && fin) begin
            job_ready[pick] <= 1'b0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            res       <= result;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a finished job leaves the ready set
  a_fin_clears_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && have && fin) |=> !job_ready[$past(pick)])
    else $error("finished job still ready");

  // every tick advances time by exactly one
  a_tick_advances_time: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |=> (cur_time == $past(cur_time) + 1'b1))
    else $error("time did not advance on tick");

  // only ready, valid slots can be picked
  a_pick_is_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && have) |-> (job_ready[pick] && slot_valid[pick]))
    else $error("picked slot not ready");

  // a result never claims completion without a running task
  a_fin_needs_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res.job_finished || res.busy_res))
    else $error("finished flag without busy");

  // no new request while a result is still being produced
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while busy");

endmodule
